// ===== design/rgbhsl_pkg.sv =====
// Package for the RGB to HSL converter: shared constants and the front-to-back record.
// Used by rgbhsl_front, rgbhsl_back and rgb_to_hsl_convert_core.
package rgbhsl_pkg;

   localparam int unsigned ChanWidth = 8;
   localparam int unsigned HueWidth  = 15;
   localparam int unsigned SatWidth  = 13;
   localparam int unsigned SumWidth  = 9;
   localparam int unsigned QuoWidth  = 13;

   localparam logic [HueWidth-1:0] HueGreenOff = 15'd7680;
   localparam logic [HueWidth-1:0] HueBlueOff  = 15'd15360;
   localparam logic [HueWidth-1:0] HueFull     = 15'd23040;

   // Classified pixel handed from the front to the back.
   typedef struct packed {
      logic                 gray;
      logic                 num_neg;
      logic [HueWidth-1:0]  offset;
      logic [ChanWidth-1:0] num_mag;
      logic [ChanWidth-1:0] delta;
      logic [ChanWidth-1:0] den;
      logic [SumWidth-1:0]  sum;
   } work_type;

endpackage

// ===== design/rgbhsl_front.sv =====
// Front end of the RGB to HSL converter: max/min, sector and denominator selection.
// Depends on rgbhsl_pkg.
module rgbhsl_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [23:0]                           in_pixel,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output rgbhsl_pkg::work_type                  out_work
);

   logic                 valid_ff, valid_in;
   rgbhsl_pkg::work_type work_ff, work_in;
   logic [7:0] r, g, b, hi, lo;
   logic [8:0] sum;
   logic       r_max, g_max;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   // classify the pixel
   always_comb begin
      r = in_pixel[23:16];
      g = in_pixel[15:8];
      b = in_pixel[7:0];
      r_max = (r >= g) && (r >= b);
      g_max = !r_max && (g >= b);
      hi = r_max ? r : (g_max ? g : b);
      lo = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
      sum = {1'b0, hi} + {1'b0, lo};
      work_in.sum   = sum;
      work_in.delta = hi - lo;
      work_in.gray  = (hi == lo);
      work_in.den   = (sum >= 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
      if (r_max) begin
         work_in.num_neg = g < b;
         work_in.num_mag = (g < b) ? b - g : g - b;
         work_in.offset  = '0;
      end else if (g_max) begin
         work_in.num_neg = b < r;
         work_in.num_mag = (b < r) ? r - b : b - r;
         work_in.offset  = rgbhsl_pkg::HueGreenOff;
      end else begin
         work_in.num_neg = r < g;
         work_in.num_mag = (r < g) ? g - r : r - g;
         work_in.offset  = rgbhsl_pkg::HueBlueOff;
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

endmodule

// ===== design/rgbhsl_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Self-contained; used by rgbhsl_back.
module rgbhsl_divider #(
   parameter int unsigned NumWidth = 20,
   parameter int unsigned DenWidth = 8,
   parameter int unsigned QWidth   = 13,
   parameter int unsigned TagWidth = 8
) (
   input  logic                clock,
   input  logic                advance,
   input  logic [NumWidth-1:0] num,
   input  logic [DenWidth-1:0] den,
   input  logic [TagWidth-1:0] tag_i,
   output logic [QWidth-1:0]   quo,
   output logic [TagWidth-1:0] tag_o
);

   // stage s holds partial remainder and quotient bits so far
   logic [NumWidth-1:0] num_ff [QWidth+1];
   logic [DenWidth:0]   rem_ff [QWidth+1];
   logic [QWidth-1:0]   q_ff   [QWidth+1];
   logic [DenWidth-1:0] den_ff [QWidth+1];
   logic [TagWidth-1:0] tag_ff [QWidth+1];

   // bits above the quotient width seed the remainder; they stay below den
   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff[0] <= num;
         rem_ff[0] <= (DenWidth+1)'(num[NumWidth-1:QWidth]);
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         tag_ff[0] <= tag_i;
      end
   end

   for (genvar s = 0; s < QWidth; s++) begin : g_stage
      logic [DenWidth+1:0] trial;
      logic [DenWidth+1:0] shifted;
      assign shifted = {rem_ff[s], num_ff[s][QWidth-1-s]};
      assign trial   = shifted - {2'b00, den_ff[s]};
      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[s+1] <= num_ff[s];
            den_ff[s+1] <= den_ff[s];
            tag_ff[s+1] <= tag_ff[s];
            if (!trial[DenWidth+1]) begin
               rem_ff[s+1] <= trial[DenWidth:0];
               q_ff[s+1]   <= {q_ff[s][QWidth-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= shifted[DenWidth:0];
               q_ff[s+1]   <= {q_ff[s][QWidth-2:0], 1'b0};
            end
         end
      end
   end

   assign quo   = q_ff[QWidth];
   assign tag_o = tag_ff[QWidth];

endmodule

// ===== design/rgbhsl_back.sv =====
// Back end of the RGB to HSL converter: two pipelined dividers and hue fixup.
// Depends on rgbhsl_pkg and rgbhsl_divider.
module rgbhsl_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  rgbhsl_pkg::work_type                  in_work,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [rgbhsl_pkg::HueWidth-1:0]       out_hue,
   output logic [rgbhsl_pkg::SatWidth-1:0]       out_sat,
   output logic [rgbhsl_pkg::SumWidth-1:0]       out_sum
);

   localparam int unsigned Depth = rgbhsl_pkg::QuoWidth + 2;
   localparam int unsigned TagW  = 1 + 1 + rgbhsl_pkg::HueWidth + rgbhsl_pkg::SumWidth;

   // pipeline valid bits; whole pipe advances when output slot frees
   logic [Depth-1:0] vld_ff, vld_in;
   logic             advance;
   logic [TagW-1:0]  tag_i, tag_o;
   logic [rgbhsl_pkg::QuoWidth-1:0] hq, sq;
   logic [19:0] hnum, snum;
   logic [rgbhsl_pkg::HueWidth-1:0] hue_in, hue_ff;
   logic [rgbhsl_pkg::SatWidth-1:0] sat_in, sat_ff;
   logic [rgbhsl_pkg::SumWidth-1:0] sum_ff;
   logic [16:0] hue_s;

   assign advance  = !vld_ff[Depth-1] || out_ready;
   assign in_ready = advance;
   assign vld_in   = {vld_ff[Depth-2:0], in_valid};

   assign hnum  = 20'(in_work.num_mag) * 20'd3840;
   assign snum  = {in_work.delta, 12'd0};
   assign tag_i = {in_work.gray, in_work.num_neg, in_work.offset, in_work.sum};

   rgbhsl_divider #(.NumWidth(20), .DenWidth(8), .QWidth(rgbhsl_pkg::QuoWidth),
                    .TagWidth(TagW)) u_hue_div (
      .clock(clock), .advance(advance), .num(hnum),
      .den(in_work.gray ? 8'd1 : in_work.delta), .tag_i(tag_i), .quo(hq), .tag_o(tag_o));

   rgbhsl_divider #(.NumWidth(20), .DenWidth(8), .QWidth(rgbhsl_pkg::QuoWidth),
                    .TagWidth(1)) u_sat_div (
      .clock(clock), .advance(advance), .num(snum),
      .den(in_work.gray ? 8'd1 : in_work.den), .tag_i(1'b0), .quo(sq), .tag_o());

   // hue = +-q + offset, wrapped
   always_comb begin
      if (tag_o[TagW-2]) begin
         hue_s = {2'b00, tag_o[TagW-3 -: rgbhsl_pkg::HueWidth]} - {4'd0, hq};
      end else begin
         hue_s = {2'b00, tag_o[TagW-3 -: rgbhsl_pkg::HueWidth]} + {4'd0, hq};
      end
      if (hue_s[16]) begin
         hue_s = hue_s + {2'b00, rgbhsl_pkg::HueFull};
      end
      hue_in = tag_o[TagW-1] ? '0 : hue_s[14:0];
      sat_in = tag_o[TagW-1] ? '0 : sq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
      if (advance) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         sum_ff <= tag_o[rgbhsl_pkg::SumWidth-1:0];
      end
   end

   assign out_valid = vld_ff[Depth-1];
   assign out_hue   = hue_ff;
   assign out_sat   = sat_ff;
   assign out_sum   = sum_ff;

endmodule

// ===== design/rgb_to_hsl_convert_core.sv =====
// RGB to HSL converter, top level: front classifier, two-entry queue, divider back end.
// Depends on rgbhsl_pkg, rgbhsl_front, rgbhsl_back.
// One pixel per clock sustained while rsp_ready stays high. An accepted pixel passes
// one front register, one queue stage, and a 15-stage back end set by the two
// bit-per-stage 13-bit dividers (hue and saturation) plus the output register.
module rgb_to_hsl_convert_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_pixel_rgb,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [14:0] rsp_hue_q6,
   output logic [12:0] rsp_saturation_q12,
   output logic [8:0]  rsp_lightness_sum
);

   logic                 f_valid, f_ready, b_ready;
   rgbhsl_pkg::work_type f_work;

   // two-entry queue between front and back
   rgbhsl_pkg::work_type q_mem [2];
   logic                 wptr_ff, rptr_ff;
   logic [1:0]           cnt_ff;
   logic                 push, pop;

   rgbhsl_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_pixel(req_pixel_rgb),
      .out_valid(f_valid), .out_ready(f_ready), .out_work(f_work));

   assign f_ready = (cnt_ff != 2'd2);
   assign push    = f_valid && f_ready;
   assign pop     = (cnt_ff != 2'd0) && b_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop)  rptr_ff <= !rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         q_mem[wptr_ff] <= f_work;
      end
   end

   rgbhsl_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(cnt_ff != 2'd0), .in_ready(b_ready), .in_work(q_mem[rptr_ff]),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_hue(rsp_hue_q6), .out_sat(rsp_saturation_q12), .out_sum(rsp_lightness_sum));

endmodule

// ===== design/rgbhsl_checker.sv =====
// Port-level checker for rgb_to_hsl_convert_core, bound to the top level.
// Depends only on the top-level ports.
module rgbhsl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [14:0] rsp_hue_q6,
   input logic [12:0] rsp_saturation_q12,
   input logic [8:0]  rsp_lightness_sum
);

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue_q6 < 15'd23040) else $error("hue out of range");

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_saturation_q12 <= 13'd4096) else $error("sat out of range");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lightness_sum <= 9'd510) else $error("sum out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue_q6))
      else $error("stalled transaction changed");

endmodule

bind rgb_to_hsl_convert_core rgbhsl_checker u_checker (.*);
